/* rtl/core/debounced_keypad_single_shot_core_macros.svh */
// Assertion macros for the keypad core.
`ifndef DEBOUNCED_KEYPAD_SINGLE_SHOT_CORE_MACROS_SVH
`define DEBOUNCED_KEYPAD_SINGLE_SHOT_CORE_MACROS_SVH

// Same-cycle implication.
`define DKSC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("keypad core check failed");

// Next-cycle implication.
`define DKSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("keypad core check failed");

`endif

/* rtl/core/dksc_pkg.sv */
package dksc_pkg;

   localparam int KEY_BITS  = 4;
   localparam int MASK_BITS = 9;
   localparam int DEB_BITS  = 16;
   localparam int CSR_BITS  = 2;
   localparam int DATA_BITS = 16;

   typedef logic [KEY_BITS-1:0] key_type;

   localparam key_type NO_CHOICE = 4'hF;

   localparam key_type RESET_REPORTED = 4'd4;
   localparam key_type RESET_SINGLE   = 4'd8;
   localparam logic [DEB_BITS-1:0] RESET_DEBOUNCE = 16'd20;

   typedef enum logic [CSR_BITS-1:0] {
      CSR_ACTIVE_HIGH_MASK  = 2'd0,
      CSR_DEBOUNCE_TIME     = 2'd1,
      CSR_SINGLE_SHOT_INDEX = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic    pressed;
      key_type key_index;
   } result_type;

endpackage

/* rtl/core/dksc_raw_pick.sv */
module dksc_raw_pick
   import dksc_pkg::*;
#(
   parameter int NUM_BUTTONS = 9
) (
   input  logic [NUM_BUTTONS-1:0] pin_levels,
   input  logic [MASK_BITS-1:0]   active_high_mask,
   output key_type                raw_choice
);

   logic [NUM_BUTTONS-1:0] pol_level;
   logic [NUM_BUTTONS-1:0] hit;

   // buttons past the mask width are active low
   for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_act
      if (g < MASK_BITS) begin : g_in
         assign pol_level[g] = active_high_mask[g];
      end else begin : g_out
         assign pol_level[g] = 1'b0;
      end
   end

   assign hit = ~(pin_levels ^ pol_level);

   // lowest index wins
   always_comb begin
      raw_choice = NO_CHOICE;
      for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
         if (hit[i]) begin
            raw_choice = KEY_BITS'(i);
         end
      end
   end

endmodule

/* rtl/core/dksc_debounce.sv */
module dksc_debounce
   import dksc_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  key_type              raw_choice,
   input  logic [TIME_BITS-1:0] now_time,
   input  logic [DEB_BITS-1:0]  debounce_time,
   input  key_type              single_shot_index,
   output result_type           result
);

   key_type              last_raw_ff, last_raw_in;
   key_type              stable_ff, stable_in;
   logic [TIME_BITS-1:0] change_time_ff, change_time_in;
   key_type              reported_ff, reported_in;
   key_type              single_held_ff, single_held_in;

   logic                 raw_changed;
   key_type              stable_mid;
   logic [TIME_BITS-1:0] elapsed;

   always_comb begin
      raw_changed    = (raw_choice != last_raw_ff);
      last_raw_in    = raw_choice;
      change_time_in = raw_changed ? now_time : change_time_ff;
      stable_mid     = (raw_changed && raw_choice == NO_CHOICE) ? NO_CHOICE : stable_ff;
      elapsed        = now_time - change_time_in;
      stable_in      = (elapsed >= TIME_BITS'(debounce_time)) ? raw_choice : stable_mid;
   end

   always_comb begin
      reported_in    = reported_ff;
      single_held_in = NO_CHOICE;
      result.pressed = 1'b0;
      if (stable_in != NO_CHOICE) begin
         if (stable_in == single_shot_index) begin
            single_held_in = stable_in;
            if (stable_in != single_held_ff) begin
               reported_in    = stable_in;
               result.pressed = 1'b1;
            end
         end else begin
            reported_in    = stable_in;
            result.pressed = 1'b1;
         end
      end
      result.key_index = reported_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff    <= NO_CHOICE;
         stable_ff      <= NO_CHOICE;
         change_time_ff <= '0;
         reported_ff    <= RESET_REPORTED;
         single_held_ff <= NO_CHOICE;
      end else if (step) begin
         last_raw_ff    <= last_raw_in;
         stable_ff      <= stable_in;
         change_time_ff <= change_time_in;
         reported_ff    <= reported_in;
         single_held_ff <= single_held_in;
      end
   end

endmodule

/* rtl/core/debounced_keypad_single_shot_core.sv */
// Each request passes the input register, then the result register.
// Throughput: one poll per cycle unless rsp_stall holds a result; the
// debounce state updates between the input and result registers.
// Reset: synchronous; clears the debounce state, both valid flags and
// restores register defaults (mask 0, debounce 20, single-shot index 8).
`include "debounced_keypad_single_shot_core_macros.svh"

module debounced_keypad_single_shot_core
   import dksc_pkg::*;
#(
   parameter int NUM_BUTTONS = 9,
   parameter int TIME_BITS   = 32
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [NUM_BUTTONS-1:0] req_pin_levels,
   input  logic [31:0]            req_now_time,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_pressed,
   output logic [KEY_BITS-1:0]    rsp_key_index,

   input  logic                   csr_write_enable,
   input  logic [CSR_BITS-1:0]    csr_index,
   input  logic [DATA_BITS-1:0]   csr_wdata
);

   logic [MASK_BITS-1:0]   mask_ff;
   logic [DEB_BITS-1:0]    debounce_ff;
   key_type                single_idx_ff;

   logic                   in_valid_ff, in_valid_in;
   logic [NUM_BUTTONS-1:0] in_levels_ff;
   logic [TIME_BITS-1:0]   in_time_ff;

   logic                   out_valid_ff, out_valid_in;
   result_type             out_ff;

   logic                   out_free;
   logic                   advance;
   key_type                raw_choice;
   result_type             result;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff       <= '0;
         debounce_ff   <= RESET_DEBOUNCE;
         single_idx_ff <= RESET_SINGLE;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_ACTIVE_HIGH_MASK:  mask_ff       <= csr_wdata[MASK_BITS-1:0];
            CSR_DEBOUNCE_TIME:     debounce_ff   <= csr_wdata[DEB_BITS-1:0];
            CSR_SINGLE_SHOT_INDEX: single_idx_ff <= csr_wdata[KEY_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign out_valid_in = out_free ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_levels_ff <= req_pin_levels;
         in_time_ff   <= req_now_time[TIME_BITS-1:0];
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   dksc_raw_pick #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_pick (
      .pin_levels       (in_levels_ff),
      .active_high_mask (mask_ff),
      .raw_choice       (raw_choice)
   );

   dksc_debounce #(
      .TIME_BITS (TIME_BITS)
   ) u_debounce (
      .clock             (clock),
      .reset             (reset),
      .step              (advance),
      .raw_choice        (raw_choice),
      .now_time          (in_time_ff),
      .debounce_time     (debounce_ff),
      .single_shot_index (single_idx_ff),
      .result            (result)
   );

   assign rsp_valid     = out_valid_ff;
   assign rsp_pressed   = out_ff.pressed;
   assign rsp_key_index = out_ff.key_index;

   `DKSC_ASSERT_NOW(a_stall_needs_item, clock, reset, req_stall, in_valid_ff)
   `DKSC_ASSERT_NEXT(a_advance_gives_result, clock, reset, advance, rsp_valid)
   `DKSC_ASSERT_NOW(a_pressed_is_button, clock, reset, rsp_valid && rsp_pressed,
      rsp_key_index != NO_CHOICE)

endmodule

/* sim/debounced_keypad_single_shot_core_test.sv */
module debounced_keypad_single_shot_core_test;
   import dksc_pkg::*;

   localparam int NUM_KEYS     = MASK_BITS;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 152;
   localparam int LONG_HOLD    = 300;
   localparam int SETTLE       = 4;
   localparam int DIR_ROWS     = 29;
   localparam int REPORT_LINES = 40;

   localparam logic [CSR_BITS-1:0] CSR_UNUSED_INDEX = 2'd3;

   typedef enum logic {ROW_POLL, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      logic [CSR_BITS-1:0] csr_idx;
      logic [31:0]         value;
      logic [NUM_KEYS-1:0] levels;
      logic                typed;
      result_type          expected;
   } scan_row_type;

   // value: tick for polls, write data for register rows
   localparam scan_row_type DIR_TABLE [DIR_ROWS] = '{
      '{ROW_POLL, '0, 32'd0,         9'h1FF, 1'b1, '{1'b0, 4'd4}},
      '{ROW_POLL, '0, 32'd100,       9'h1FE, 1'b1, '{1'b0, 4'd4}},
      '{ROW_POLL, '0, 32'd119,       9'h1FE, 1'b1, '{1'b0, 4'd4}},
      '{ROW_POLL, '0, 32'd120,       9'h1FE, 1'b1, '{1'b1, 4'd0}},
      '{ROW_POLL, '0, 32'd121,       9'h000, 1'b1, '{1'b1, 4'd0}},
      '{ROW_POLL, '0, 32'd122,       9'h1FF, 1'b1, '{1'b0, 4'd0}},
      '{ROW_POLL, '0, 32'd130,       9'h0FF, 1'b1, '{1'b0, 4'd0}},
      '{ROW_POLL, '0, 32'd150,       9'h0FF, 1'b1, '{1'b1, 4'd8}},
      '{ROW_POLL, '0, 32'd151,       9'h0FF, 1'b1, '{1'b0, 4'd8}},
      '{ROW_POLL, '0, 32'd152,       9'h0FF, 1'b0, '0},
      '{ROW_POLL, '0, 32'hFFFF_FFF0, 9'h1FD, 1'b1, '{1'b0, 4'd8}},
      '{ROW_POLL, '0, 32'h0000_0004, 9'h1FD, 1'b1, '{1'b1, 4'd1}},
      '{ROW_CSR,  CSR_DEBOUNCE_TIME,     32'h0000, '0, 1'b0, '0},
      '{ROW_POLL, '0, 32'hFFFF_FFFF, 9'h1FB, 1'b1, '{1'b1, 4'd2}},
      '{ROW_CSR,  CSR_ACTIVE_HIGH_MASK,  32'h01FF, '0, 1'b0, '0},
      '{ROW_CSR,  CSR_SINGLE_SHOT_INDEX, 32'h0002, '0, 1'b0, '0},
      '{ROW_POLL, '0, 32'd0,         9'h004, 1'b1, '{1'b1, 4'd2}},
      '{ROW_POLL, '0, 32'd1,         9'h1FC, 1'b1, '{1'b0, 4'd2}},
      '{ROW_CSR,  CSR_SINGLE_SHOT_INDEX, 32'hFFFF, '0, 1'b0, '0},
      '{ROW_POLL, '0, 32'd2,         9'h004, 1'b1, '{1'b1, 4'd2}},
      '{ROW_CSR,  CSR_UNUSED_INDEX,      32'h0000, '0, 1'b0, '0},
      '{ROW_POLL, '0, 32'd3,         9'h004, 1'b0, '0},
      '{ROW_CSR,  CSR_ACTIVE_HIGH_MASK,  32'hFE00, '0, 1'b0, '0},
      '{ROW_POLL, '0, 32'd4,         9'h000, 1'b1, '{1'b1, 4'd0}},
      '{ROW_CSR,  CSR_DEBOUNCE_TIME,     32'hFFFF, '0, 1'b0, '0},
      '{ROW_POLL, '0, 32'd5,         9'h1FF, 1'b1, '{1'b0, 4'd0}},
      '{ROW_POLL, '0, 32'd1000,      9'h1FE, 1'b1, '{1'b0, 4'd0}},
      '{ROW_POLL, '0, 32'd66534,     9'h1FE, 1'b0, '0},
      '{ROW_POLL, '0, 32'd66535,     9'h1FE, 1'b1, '{1'b1, 4'd0}}
   };

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   logic [NUM_KEYS-1:0]   req_pin_levels   = '0;
   logic [31:0]           req_now_time     = '0;
   logic                  rsp_valid;
   logic                  rsp_stall        = 1'b0;
   logic                  rsp_pressed;
   logic [KEY_BITS-1:0]   rsp_key_index;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_BITS-1:0]   csr_index        = '0;
   logic [DATA_BITS-1:0]  csr_wdata        = '0;

   // predictor copy of registers and debounce state
   logic [NUM_KEYS-1:0]   pol_mask;
   logic [DEB_BITS-1:0]   settle_ms;
   key_type               shot_key;
   key_type               prev_raw;
   key_type               settled_key;
   logic [31:0]           change_tick;
   key_type               shown_key;
   key_type               shot_latched;

   result_type            pending_results [$];
   result_type            head_result;
   int                    mismatches      = 0;
   int                    cycle_count     = 0;
   int                    burst_left      = 0;
   int                    hold_count      = 0;
   int                    stall_tick      = 0;
   logic                  long_hold_req   = 1'b0;
   logic                  long_hold_taken = 1'b0;

   debounced_keypad_single_shot_core #(
      .NUM_BUTTONS(NUM_KEYS),
      .TIME_BITS  (32)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pin_levels  (req_pin_levels),
      .req_now_time    (req_now_time),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pressed     (rsp_pressed),
      .rsp_key_index   (rsp_key_index),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= REPORT_LINES)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   function automatic void keypad_reset();
      pol_mask     = '0;
      settle_ms    = RESET_DEBOUNCE;
      shot_key     = RESET_SINGLE;
      prev_raw     = NO_CHOICE;
      settled_key  = NO_CHOICE;
      change_tick  = '0;
      shown_key    = RESET_REPORTED;
      shot_latched = NO_CHOICE;
   endfunction

   function automatic result_type scan_predict(input logic [NUM_KEYS-1:0] lv,
                                               input logic [31:0] tick);
      key_type     raw;
      logic [31:0] elapsed;
      result_type  res;
      raw = NO_CHOICE;
      for (int i = NUM_KEYS - 1; i >= 0; i--)
         if (lv[i] == pol_mask[i]) raw = key_type'(i);
      if (raw != prev_raw) begin
         prev_raw    = raw;
         change_tick = tick;
         if (raw == NO_CHOICE) settled_key = NO_CHOICE;
      end
      elapsed = tick - change_tick;
      if (elapsed >= {16'd0, settle_ms}) settled_key = prev_raw;
      res.pressed = 1'b0;
      if (settled_key != NO_CHOICE) begin
         if (settled_key == shot_key) begin
            if (settled_key != shot_latched) begin
               shot_latched = settled_key;
               shown_key    = settled_key;
               res.pressed  = 1'b1;
            end
         end else begin
            shot_latched = NO_CHOICE;
            shown_key    = settled_key;
            res.pressed  = 1'b1;
         end
      end else begin
         shot_latched = NO_CHOICE;
      end
      res.key_index = shown_key;
      return res;
   endfunction

   // k == NUM_KEYS gives no active button
   function automatic logic [NUM_KEYS-1:0] levels_for(input int k);
      logic [NUM_KEYS-1:0] act;
      act = NUM_KEYS'($urandom_range(0, (1 << NUM_KEYS) - 1));
      if (k >= NUM_KEYS) begin
         act = '0;
      end else begin
         act    = act & ~((NUM_KEYS'(1) << k) - NUM_KEYS'(1));
         act[k] = 1'b1;
      end
      return ~(act ^ pol_mask);
   endfunction

   task automatic send_poll(input logic [NUM_KEYS-1:0] lv, input logic [31:0] tick,
                            input logic typed, input result_type typed_result);
      int         gap;
      result_type res;
      csr_write_enable <= 1'b0;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_pin_levels <= lv;
      req_now_time   <= tick;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      res = scan_predict(lv, tick);
      pending_results.push_back(typed ? typed_result : res);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic csr_write(input logic [CSR_BITS-1:0] idx, input logic [DATA_BITS-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= data;
      @(posedge clock);
      case (idx)
         CSR_ACTIVE_HIGH_MASK:  pol_mask  = data[NUM_KEYS-1:0];
         CSR_DEBOUNCE_TIME:     settle_ms = data[DEB_BITS-1:0];
         CSR_SINGLE_SHOT_INDEX: shot_key  = data[KEY_BITS-1:0];
         default: ;
      endcase
   endtask

   // receiver stall pattern, with one long hold-off on request
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      if (hold_count != 0) begin
         hold_count <= hold_count - 1;
         rsp_stall  <= 1'b1;
      end else if (long_hold_req && !long_hold_taken) begin
         long_hold_taken <= 1'b1;
         hold_count      <= LONG_HOLD;
         rsp_stall       <= 1'b1;
      end else begin
         case (stall_tick[8:7])
            2'd0:    rsp_stall <= 1'b0;
            2'd1:    rsp_stall <= ($urandom_range(0, 1) == 0);
            2'd2:    rsp_stall <= (stall_tick[2:0] == 3'd5);
            default: rsp_stall <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result item with nothing expected");
         end else begin
            head_result = pending_results.pop_front();
            if (rsp_pressed !== head_result.pressed)
               report_mismatch($sformatf("pressed %b, expected %b",
                                         rsp_pressed, head_result.pressed));
            if (rsp_key_index !== head_result.key_index)
               report_mismatch($sformatf("key_index %0d, expected %0d",
                                         rsp_key_index, head_result.key_index));
         end
      end
   end

   initial begin
      int                   n;
      int                   hold_len;
      int                   target;
      int                   step_max;
      logic [NUM_KEYS-1:0]  lv;
      logic [31:0]          cur_tick;
      logic [DATA_BITS-1:0] wd;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      keypad_reset();

      for (int r = 0; r < DIR_ROWS; r++) begin
         if (DIR_TABLE[r].kind == ROW_CSR) begin
            if (r == 0 || DIR_TABLE[r-1].kind != ROW_CSR) drain_results();
            csr_write(DIR_TABLE[r].csr_idx, DIR_TABLE[r].value[DATA_BITS-1:0]);
         end else begin
            send_poll(DIR_TABLE[r].levels, DIR_TABLE[r].value,
                      DIR_TABLE[r].typed, DIR_TABLE[r].expected);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         drain_results();
         case (ph)
            0:       wd = 16'h0000;
            1:       wd = 16'hFFFF;
            default: wd = DATA_BITS'($urandom);
         endcase
         csr_write(CSR_ACTIVE_HIGH_MASK, wd);
         case (ph)
            2:       wd = 16'd0;
            5:       wd = 16'hFFFF;
            7:       wd = 16'd1;
            default: wd = DATA_BITS'($urandom_range(1, 40));
         endcase
         csr_write(CSR_DEBOUNCE_TIME, wd);
         case (ph)
            0:       wd = 16'd0;
            1:       wd = 16'd8;
            default: wd = ($urandom_range(0, 3) == 0) ? DATA_BITS'($urandom_range(9, 15))
                                                      : DATA_BITS'($urandom_range(0, 8));
         endcase
         if (ph % 3 == 2) wd = wd | (DATA_BITS'($urandom) & 16'hFFF0);
         csr_write(CSR_SINGLE_SHOT_INDEX, wd);
         if (ph % 3 == 0) csr_write(CSR_UNUSED_INDEX, DATA_BITS'($urandom));
         if (ph == 4) long_hold_req <= 1'b1;

         step_max = (settle_ms > 40) ? int'(settle_ms) / 2 + 1 : 8;
         cur_tick = $urandom;
         n = 0;
         while (n < PHASE_ITEMS) begin
            if ($urandom_range(0, 3) == 0 && shot_key < NUM_KEYS)
               target = shot_key;
            else
               target = $urandom_range(0, NUM_KEYS);
            hold_len = $urandom_range(1, 12);
            for (int h = 0; h < hold_len && n < PHASE_ITEMS; h++) begin
               if ($urandom_range(0, 15) == 0)
                  lv = NUM_KEYS'($urandom);
               else
                  lv = levels_for(target);
               if ($urandom_range(0, 31) == 0)
                  cur_tick = $urandom;
               else
                  cur_tick = cur_tick + 32'($urandom_range(0, step_max));
               send_poll(lv, cur_tick, 1'b0, '0);
               n++;
            end
         end
      end

      drain_results();
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
